### sv/vrt_pkg.sv
// ============================================================================
// Voxel ray traversal package
// Shared types, codes and a helper function for the traversal core.
// ============================================================================
package vrt_pkg;

    localparam int POS_W  = 40;
    localparam int DIR_W  = 16;
    localparam int DIST_W = 32;

    localparam logic [DIST_W-1:0] DIST_INF    = '1;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 32'h0010_0000;

    // Step sign codes: zero, plus one and minus one.
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_AXIS,
        S_ROOT,
        S_CROSS,
        S_PICK,
        S_EMIT
    } t_ctrl_state;

    typedef enum logic [1:0] {
        RP_IDLE,
        RP_DIV,
        RP_SQRT
    } t_root_phase;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic       root_start;
        logic       cross_wr;
        logic       pick;
        logic       pick_step;
        logic       emit;
        logic [1:0] axis;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_done;
        logic mag_zero;
    } t_status;

    // Nearest crossing; ties go to the later axis.
    function automatic logic [1:0] pick_axis(input logic [DIST_W-1:0] cx,
                                             input logic [DIST_W-1:0] cy,
                                             input logic [DIST_W-1:0] cz);
        logic [1:0] res;
        if (cx < cy && cx < cz) begin
            res = AXIS_X;
        end else if (cy < cz) begin
            res = AXIS_Y;
        end else begin
            res = AXIS_Z;
        end
        return res;
    endfunction

endpackage

### sv/voxel_ray_traversal_core.sv
// ============================================================================
// Voxel ray traversal core
// Walks a ray through a grid of unit voxels, one voxel per step word.
// ============================================================================
// A step word is taken in, then the nearest crossing is chosen and the ray
// moves, then the result register is loaded. For a start word, per axis
// with a nonzero direction component, one shared unit performs a bit-serial
// division followed by a bit-serial square root, and set-up adds squaring
// and crossing writes. The result register lets the next word be accepted
// while a result still waits to be taken. The max_distance register is
// written through the configuration channel, which is always ready, and
// should only be written while the core is idle.
module voxel_ray_traversal_core #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic signed [39:0]            i_pos_x,
    input  logic signed [39:0]            i_pos_y,
    input  logic signed [39:0]            i_pos_z,
    input  logic signed [15:0]            i_dir_x,
    input  logic signed [15:0]            i_dir_y,
    input  logic signed [15:0]            i_dir_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_voxel_x,
    output logic signed [COORD_BITS-1:0]  o_voxel_y,
    output logic signed [COORD_BITS-1:0]  o_voxel_z,
    output logic [2:0]                    o_entry_face,
    output logic [31:0]                   o_travel_distance,
    output logic                          o_keep_going
);
    import vrt_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // Controller.
    vrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Datapath.
    vrt_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_dir_x           (i_dir_x),
        .i_dir_y           (i_dir_y),
        .i_dir_z           (i_dir_z),
        .o_voxel_x         (o_voxel_x),
        .o_voxel_y         (o_voxel_y),
        .o_voxel_z         (o_voxel_z),
        .o_entry_face      (o_entry_face),
        .o_travel_distance (o_travel_distance),
        .o_keep_going      (o_keep_going)
    );

endmodule

### sv/vrt_root_unit.sv
// ============================================================================
// Shared divide and square root unit
// Restoring division of a 64-bit numerator by a 32-bit divisor, one quotient
// bit a cycle, followed by a square root of the quotient, one root bit a cycle.
// ============================================================================
module vrt_root_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_root
);
    import vrt_pkg::*;

    t_root_phase r_phase, n_phase;
    logic [5:0]  r_cnt;
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_den;
    logic [31:0] r_root;
    logic        r_done;

    logic [33:0] div_rem;
    logic [33:0] div_sub;
    logic        div_bit;
    logic [34:0] sq_rem;
    logic [34:0] sq_trial;
    logic [34:0] sq_sub;
    logic        sq_bit;

    // One division step and one root step.
    always_comb begin
        div_rem  = {r_rem[32:0], r_val[63]};
        div_sub  = div_rem - {2'b00, r_den};
        div_bit  = (div_rem >= {2'b00, r_den});
        sq_rem   = {r_rem[32:0], r_val[63:62]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_sub   = sq_rem - sq_trial;
        sq_bit   = (sq_rem >= sq_trial);
    end

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            RP_IDLE: begin
                if (i_start) begin
                    n_phase = RP_DIV;
                end
            end
            RP_DIV: begin
                if (r_cnt == 6'd0) begin
                    n_phase = RP_SQRT;
                end
            end
            RP_SQRT: begin
                if (r_cnt == 6'd0) begin
                    n_phase = RP_IDLE;
                end
            end
            default: n_phase = RP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RP_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == RP_SQRT) && (r_cnt == 6'd0);
            case (r_phase)
                RP_IDLE: r_cnt <= 6'd63;
                RP_DIV:  r_cnt <= (r_cnt == 6'd0) ? 6'd31 : r_cnt - 6'd1;
                RP_SQRT: r_cnt <= r_cnt - 6'd1;
                default: r_cnt <= '0;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            RP_IDLE: begin
                if (i_start) begin
                    r_val <= i_num;
                    r_den <= i_den;
                    r_rem <= '0;
                end
            end
            RP_DIV: begin
                r_val <= {r_val[62:0], div_bit};
                if (r_cnt == 6'd0) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem <= div_bit ? div_sub : div_rem;
                end
            end
            RP_SQRT: begin
                r_val  <= {r_val[61:0], 2'b00};
                r_rem  <= sq_bit ? sq_sub[33:0] : sq_rem[33:0];
                r_root <= {r_root[30:0], sq_bit};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/vrt_datapath.sv
// ============================================================================
// Traversal datapath
// Holds the ray state, the set-up arithmetic, the step logic, the
// max_distance register and the result word register.
// ============================================================================
module vrt_datapath #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vrt_pkg::t_cmd                 i_cmd,
    output vrt_pkg::t_status              o_status,
    input  logic                          i_cfg_we,
    input  logic [31:0]                   i_cfg_data,
    input  logic signed [39:0]            i_pos_x,
    input  logic signed [39:0]            i_pos_y,
    input  logic signed [39:0]            i_pos_z,
    input  logic signed [15:0]            i_dir_x,
    input  logic signed [15:0]            i_dir_y,
    input  logic signed [15:0]            i_dir_z,
    output logic signed [COORD_BITS-1:0]  o_voxel_x,
    output logic signed [COORD_BITS-1:0]  o_voxel_y,
    output logic signed [COORD_BITS-1:0]  o_voxel_z,
    output logic [2:0]                    o_entry_face,
    output logic [31:0]                   o_travel_distance,
    output logic                          o_keep_going
);
    import vrt_pkg::*;

    localparam int G_W    = FRAC_BITS + 1;
    localparam int PROD_W = DIST_W + G_W;

    logic [COORD_BITS-1:0] r_voxel [3];
    logic [DIST_W-1:0]     r_cross [3];
    logic [DIST_W-1:0]     r_step  [3];
    logic [1:0]            r_sign  [3];
    logic [15:0]           r_mag   [3];
    logic [FRAC_BITS-1:0]  r_frac  [3];
    logic [1:0]            r_axis;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_go;
    logic [DIST_W-1:0]     r_max;
    logic [31:0]           r_sq;
    logic [PROD_W-1:0]     r_prod;

    logic [COORD_BITS-1:0] r_out_vox [3];
    logic [2:0]            r_out_face;
    logic [DIST_W-1:0]     r_out_dist;
    logic                  r_out_go;

    logic signed [39:0]    pos_in [3];
    logic signed [15:0]    dir_in [3];
    logic [15:0]           cur_mag;
    logic [31:0]           cur_sqr;
    logic [G_W-1:0]        cur_g;
    logic [31:0]           root;
    logic                  root_done;
    logic [DIST_W:0]       cross_full;
    logic [1:0]            pick_a;
    logic [DIST_W:0]       adv;

    assign pos_in[0] = i_pos_x;
    assign pos_in[1] = i_pos_y;
    assign pos_in[2] = i_pos_z;
    assign dir_in[0] = i_dir_x;
    assign dir_in[1] = i_dir_y;
    assign dir_in[2] = i_dir_z;

    // Shared squarer, the fraction gap for the current axis, the crossing scale-down and the nearest-axis pick.
    always_comb begin
        cur_mag = r_mag[i_cmd.axis];
        cur_sqr = {16'd0, cur_mag} * {16'd0, cur_mag};
        if (r_sign[i_cmd.axis] == SIGN_POS) begin
            cur_g = G_W'(1) << FRAC_BITS;
            cur_g = cur_g - {1'b0, r_frac[i_cmd.axis]};
        end else begin
            cur_g = {1'b0, r_frac[i_cmd.axis]};
        end
        cross_full = (DIST_W+1)'(r_prod >> FRAC_BITS);
        pick_a     = pick_axis(r_cross[0], r_cross[1], r_cross[2]);
        adv        = {1'b0, r_cross[pick_a]} + {1'b0, r_step[pick_a]};
    end

    vrt_root_unit u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_num   ({r_sq, 32'd0}),
        .i_den   (cur_sqr),
        .o_done  (root_done),
        .o_root  (root)
    );

    assign o_status.root_done = root_done;
    assign o_status.mag_zero  = (cur_mag == 16'd0);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_DIST_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Ray state: load, set-up, crossing write and step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_voxel[a] <= '0;
                r_cross[a] <= DIST_INF;
                r_step[a]  <= '0;
                r_sign[a]  <= SIGN_ZERO;
            end
            r_axis <= AXIS_X;
            r_dist <= '0;
            r_go   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                for (int a = 0; a < 3; a++) begin
                    if (dir_in[a] == 16'sd0) begin
                        r_sign[a] <= SIGN_ZERO;
                        r_mag[a]  <= '0;
                    end else if (dir_in[a][15]) begin
                        r_sign[a] <= SIGN_NEG;
                        r_mag[a]  <= 16'(-dir_in[a]);
                    end else begin
                        r_sign[a] <= SIGN_POS;
                        r_mag[a]  <= dir_in[a];
                    end
                    r_voxel[a] <= COORD_BITS'(64'(signed'(pos_in[a])) >>> FRAC_BITS);
                    r_frac[a]  <= pos_in[a][FRAC_BITS-1:0];
                end
                r_sq <= '0;
            end
            if (i_cmd.sq_en) begin
                r_sq <= r_sq + cur_sqr;
            end
            if (root_done) begin
                r_step[i_cmd.axis] <= root;
                r_prod <= {{(PROD_W-DIST_W){1'b0}}, root}
                        * {{(PROD_W-G_W){1'b0}}, cur_g};
            end
            if (i_cmd.cross_wr) begin
                if (cur_mag == 16'd0) begin
                    r_step[i_cmd.axis]  <= '0;
                    r_cross[i_cmd.axis] <= DIST_INF;
                end else begin
                    r_cross[i_cmd.axis] <= cross_full[DIST_W] ? DIST_INF
                                                              : cross_full[DIST_W-1:0];
                end
            end
            if (i_cmd.pick) begin
                r_axis <= pick_a;
                r_dist <= r_cross[pick_a];
                if (i_cmd.pick_step && (r_cross[pick_a] > r_max)) begin
                    r_go <= 1'b0;
                end else begin
                    r_go <= 1'b1;
                    if (i_cmd.pick_step) begin
                        r_cross[pick_a] <= adv[DIST_W] ? DIST_INF : adv[DIST_W-1:0];
                        if (r_sign[pick_a] == SIGN_POS) begin
                            r_voxel[pick_a] <= r_voxel[pick_a] + COORD_BITS'(1);
                        end else if (r_sign[pick_a] == SIGN_NEG) begin
                            r_voxel[pick_a] <= r_voxel[pick_a] - COORD_BITS'(1);
                        end
                    end
                end
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int a = 0; a < 3; a++) begin
                r_out_vox[a] <= r_voxel[a];
            end
            r_out_face <= {r_axis, 1'b0} + {2'b00, (r_sign[r_axis] == SIGN_NEG)};
            r_out_dist <= r_dist;
            r_out_go   <= r_go;
        end
    end

    assign o_voxel_x         = r_out_vox[0];
    assign o_voxel_y         = r_out_vox[1];
    assign o_voxel_z         = r_out_vox[2];
    assign o_entry_face      = r_out_face;
    assign o_travel_distance = r_out_dist;
    assign o_keep_going      = r_out_go;

endmodule

### sv/vrt_ctrl.sv
// ============================================================================
// Traversal controller
// Sequences ray set-up over the three axes, the step decision and the
// hand-over of each result word.
// ============================================================================
module vrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vrt_pkg::t_cmd    o_cmd,
    input  vrt_pkg::t_status i_status
);
    import vrt_pkg::*;

    t_ctrl_state r_state, n_state;
    logic [1:0]  r_axis, n_axis;
    logic        r_is_step, n_is_step;
    logic        r_out_valid;
    logic        accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_is_step   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_axis    <= n_axis;
            r_is_step <= n_is_step;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_is_step = r_is_step;
        o_cmd     = '0;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_step = i_action;
                    n_axis    = AXIS_X;
                    o_cmd.load = !i_action;
                    n_state   = i_action ? S_PICK : S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_en = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_axis  = AXIS_X;
                    n_state = S_AXIS;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_AXIS: begin
                if (i_status.mag_zero) begin
                    n_state = S_CROSS;
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_status.root_done) begin
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                o_cmd.cross_wr = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_state = S_PICK;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_AXIS;
                end
            end
            S_PICK: begin
                o_cmd.pick      = 1'b1;
                o_cmd.pick_step = r_is_step;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### sv/vrt_checker.sv
// ============================================================================
// Traversal core port checker
// Watches the core's ports for handshake and sequencing slips.
// ============================================================================
module vrt_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [31:0]                  i_cfg_data,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_action,
    input logic signed [39:0]           i_pos_x,
    input logic signed [39:0]           i_pos_y,
    input logic signed [39:0]           i_pos_z,
    input logic signed [15:0]           i_dir_x,
    input logic signed [15:0]           i_dir_y,
    input logic signed [15:0]           i_dir_z,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [COORD_BITS-1:0] o_voxel_x,
    input logic signed [COORD_BITS-1:0] o_voxel_y,
    input logic signed [COORD_BITS-1:0] o_voxel_z,
    input logic [2:0]                   o_entry_face,
    input logic [31:0]                  o_travel_distance,
    input logic                         o_keep_going
);

    // A waiting result word stays valid, and its distance, X voxel and entry face hold still, until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_travel_distance)
            && $stable(o_voxel_x) && $stable(o_entry_face))
        else $error("result word changed while stalled");

    // One word at a time: the core is busy in the cycle after an acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice back to back");

    // The entry face code stays within the six faces.
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_face != 3'd6 && o_entry_face != 3'd7)
        else $error("entry face out of range");

    // A new result only appears after the core has been busy.
    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result word appeared without work");

endmodule

bind voxel_ray_traversal_core vrt_checker #(.COORD_BITS(COORD_BITS)) u_vrt_checker (.*);
